// ===== src/rle_pkg.sv =====
// Shared constants, types and helper functions of the RGB LED effect engine.
`default_nettype none

package rle_pkg;

    localparam int FLOW_DEPTH   = 8;
    localparam int TICK_MS      = 10;
    localparam int SINE_ENTRIES = 256;

    localparam int FLOW_IDX_W = $clog2(FLOW_DEPTH);
    localparam int FLOW_CW    = $clog2(FLOW_DEPTH + 1);
    localparam int SINE_W     = $clog2(SINE_ENTRIES);
    localparam int N_W        = $clog2(65535 / TICK_MS + 1);
    localparam int DIV_W      = (16 + SINE_W > 24) ? 16 + SINE_W : 24;
    localparam int DIV_CW     = $clog2(DIV_W + 1);
    localparam int DVS_W      = 16;
    localparam int CFG_AW     = 5;

    localparam logic [DVS_W-1:0] LEVEL_DIV = DVS_W'(255 * 255);
    localparam logic [DVS_W-1:0] BLEND_DIV = DVS_W'(255);
    localparam logic [DVS_W-1:0] DUTY_DIV  = DVS_W'(50);
    localparam logic [6:0]       DUTY_MAX  = 7'd100;

    // Effect modes
    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_BREATH = 3'd1;
    localparam logic [2:0] MODE_FLOW   = 3'd2;
    localparam logic [2:0] MODE_GRAD   = 3'd3;
    localparam logic [2:0] MODE_BLINK  = 3'd4;

    // Request actions
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_PERIOD   = 3'd1;
    localparam logic [2:0] REG_COLOR_A  = 3'd2;
    localparam logic [2:0] REG_COLOR_B  = 3'd3;
    localparam logic [2:0] REG_BRIGHT   = 3'd4;
    localparam logic [2:0] REG_DUTY     = 3'd5;
    localparam logic [2:0] REG_FLOW_CNT = 3'd6;

    // Color channels (byte lanes of an aRGB word)
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] period;
        logic [31:0] color_a;
        logic [31:0] color_b;
        logic [7:0]  brightness;
        logic [6:0]  duty;
        logic [3:0]  flow_count;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef logic [7:0] sine_tab_t [SINE_ENTRIES];

    function automatic longint unsigned q24_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 24;
    endfunction

    function automatic longint unsigned sub_sat(longint unsigned a, longint unsigned b);
        return (b > a) ? 64'd0 : a - b;
    endfunction

    // (1 + sin) / 2 in Q0.8, built at elaboration from a Q24 Taylor series
    function automatic sine_tab_t build_sine();
        sine_tab_t       tab;
        longint unsigned one;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned a;
        longint unsigned x;
        longint unsigned t;
        longint unsigned v;
        longint unsigned num;
        one = 64'd1 << 24;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            quad = (64'(4 * i)) >> SINE_W;
            rem  = 64'(4 * i) - (quad << SINE_W);
            a    = (rem * 64'd26353589) >> SINE_W;
            x    = q24_mul(a, a);
            if (quad[0] == 1'b0)
            begin
                t = sub_sat(one, x / 72);
                t = sub_sat(one, q24_mul(x, t) / 42);
                t = sub_sat(one, q24_mul(x, t) / 20);
                t = sub_sat(one, q24_mul(x, t) / 6);
                v = q24_mul(a, t);
            end
            else
            begin
                t = sub_sat(one, x / 90);
                t = sub_sat(one, q24_mul(x, t) / 56);
                t = sub_sat(one, q24_mul(x, t) / 30);
                t = sub_sat(one, q24_mul(x, t) / 12);
                t = sub_sat(one, q24_mul(x, t) / 2);
                v = t;
            end
            if (v > one)
                v = one;
            num    = (quad < 2) ? one + v : one - v;
            // Round half up over 2.0 in Q24
            tab[i] = 8'((num * 255 + one) >> 25);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    function automatic logic [7:0] col_byte(logic [31:0] col, logic [1:0] ch);
        logic [7:0] b;
        case (ch)
            CH_RED:   b = col[23:16];
            CH_GREEN: b = col[15:8];
            CH_BLUE:  b = col[7:0];
            default:  b = col[31:24];
        endcase
        return b;
    endfunction

    // Alpha zero with any color bit set counts as full alpha
    function automatic logic [7:0] alpha_eff(logic [31:0] col);
        return (col[31:24] == 8'd0 && col[23:0] != 24'd0) ? 8'hFF : col[31:24];
    endfunction

endpackage

`default_nettype wire

// ===== src/rgb_led_effect_engine.sv =====
// Top level of the RGB LED effect engine: request sequencer and output stage.
`default_nettype none

// Each request carries an action and a millisecond time stamp. A tick advances
// the effect chosen by the mode register (off, breathing, flow, gradient, blink) once
// its interval has passed and updates the three 16-bit compare levels; a
// restart rewinds the effect; a load writes one flow-table color. One result
// comes back per request with the held levels and a written flag. All the
// divides run through one shared bit-serial divider that retires one
// quotient bit per cycle. The next request is accepted as soon as the
// sequencer is back in idle, even while a result waits to be taken. The flow
// table comes out of reset undefined; read only written entries.
// Configuration registers sit on the APB port at 4 * index.
module rgb_led_effect_engine (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [1:0]                    action,
    input  wire [31:0]                   now_ms,
    input  wire [2:0]                    flow_index,
    input  wire [31:0]                   flow_color,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [15:0]                  red_level,
    output logic [15:0]                  green_level,
    output logic [15:0]                  blue_level,
    output logic                         pwm_written,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [rle_pkg::CFG_AW-1:0]    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NDIV = 4'd1;  // step count = period / tick
    localparam logic [3:0] S_SDIV = 4'd2;  // step-based divide per mode
    localparam logic [3:0] S_ODIV = 4'd3;  // blink on-time
    localparam logic [3:0] S_BL   = 4'd4;  // launch one blend channel
    localparam logic [3:0] S_BDIV = 4'd5;  // blend channel divide
    localparam logic [3:0] S_MUL1 = 4'd6;  // color * scale
    localparam logic [3:0] S_MUL2 = 4'd7;  // * brightness, launch level divide
    localparam logic [3:0] S_LDIV = 4'd8;  // level divide
    localparam logic [3:0] S_OUT  = 4'd9;  // hand result to output register

    rle_pkg::cfg_t      cfg;
    rle_pkg::div_stat_t div_stat;
    logic [rle_pkg::DIV_W-1:0] div_quo;
    logic [rle_pkg::DVS_W-1:0] div_rem;

    logic [3:0]                    state_reg;
    logic                          go_reg;
    logic [rle_pkg::DIV_W-1:0]     div_a_reg;
    logic [rle_pkg::DVS_W-1:0]     div_b_reg;
    logic [31:0]                   last_reg;
    logic [15:0]                   step_reg;
    logic [7:0]                    lvl_reg [3];
    logic [rle_pkg::N_W-1:0]       n_reg;
    logic [31:0]                   col_reg;
    logic [7:0]                    sc_reg;
    logic [7:0]                    ratio_reg;
    logic [rle_pkg::N_W-1:0]       remk_reg;
    logic [31:0]                   mix_reg;
    logic [1:0]                    chan_reg;
    logic [15:0]                   prod_reg;
    logic                          written_reg;
    logic                          out_valid_reg;
    logic [15:0]                   red_reg;
    logic [15:0]                   green_reg;
    logic [15:0]                   blue_reg;
    logic                          wr_out_reg;
    logic [31:0]                   flow_tab_reg [rle_pkg::FLOW_DEPTH];

    // Combinational helpers
    logic                          accept;
    logic [31:0]                   elapsed;
    logic                          tick_go;
    logic [rle_pkg::N_W-1:0]       n_val;
    logic [15:0]                   step_inc;
    logic [15:0]                   step_wrap;
    logic [rle_pkg::FLOW_CW-1:0]   cnt;
    logic [rle_pkg::FLOW_IDX_W-1:0] flow_st;
    logic [rle_pkg::FLOW_CW-1:0]   flow_st_inc;
    logic [31:0]                   flow_col;
    logic [7:0]                    ratio_val;
    logic [7:0]                    c1;
    logic [7:0]                    c2;
    logic                          bneg;
    logic [7:0]                    bmag;
    logic [7:0]                    bbyte;
    logic [31:0]                   mix_next;

    rle_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rle_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .stat     (div_stat),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign elapsed  = now_ms - last_reg;

    always_comb
    begin
        // Tick is due only for a real mode whose interval has elapsed
        if (cfg.mode inside {[rle_pkg::MODE_BREATH:rle_pkg::MODE_BLINK]})
        begin
            if (cfg.mode == rle_pkg::MODE_FLOW)
                tick_go = elapsed >= {16'd0, cfg.period};
            else
                tick_go = elapsed >= 32'(rle_pkg::TICK_MS);
        end
        else
            tick_go = 1'b0;

        n_val     = (div_quo == '0) ? rle_pkg::N_W'(1) : div_quo[rle_pkg::N_W-1:0];
        step_inc  = step_reg + 16'd1;
        step_wrap = (step_inc >= 16'(n_val)) ? 16'd0 : step_inc;

        if (cfg.flow_count == 4'd0)
            cnt = rle_pkg::FLOW_CW'(1);
        else if (32'(cfg.flow_count) > rle_pkg::FLOW_DEPTH)
            cnt = rle_pkg::FLOW_CW'(rle_pkg::FLOW_DEPTH);
        else
            cnt = rle_pkg::FLOW_CW'(cfg.flow_count);

        flow_st     = (step_reg >= 16'(cnt)) ? '0 : step_reg[rle_pkg::FLOW_IDX_W-1:0];
        flow_st_inc = rle_pkg::FLOW_CW'(flow_st) + rle_pkg::FLOW_CW'(1);
        flow_col    = flow_tab_reg[flow_st];

        ratio_val = (div_quo > rle_pkg::DIV_W'(255)) ? 8'hFF : div_quo[7:0];

        // Blend channel: c1 + trunc((c2 - c1) * ratio / 255)
        c1    = rle_pkg::col_byte(cfg.color_a, chan_reg);
        c2    = rle_pkg::col_byte(cfg.color_b, chan_reg);
        bneg  = c2 < c1;
        bmag  = bneg ? c1 - c2 : c2 - c1;
        bbyte = bneg ? c1 - div_quo[7:0] : c1 + div_quo[7:0];

        mix_next = mix_reg;
        case (chan_reg)
            rle_pkg::CH_RED:   mix_next[23:16] = bbyte;
            rle_pkg::CH_GREEN: mix_next[15:8]  = bbyte;
            rle_pkg::CH_BLUE:  mix_next[7:0]   = bbyte;
            default:           mix_next[31:24] = bbyte;
        endcase
    end

    // Flow table: written by load requests, no reset
    always_ff @(posedge clk)
    begin
        if (accept && action == rle_pkg::ACT_LOAD && 32'(flow_index) < rle_pkg::FLOW_DEPTH)
            flow_tab_reg[rle_pkg::FLOW_IDX_W'(flow_index)] <= flow_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            div_a_reg     <= '0;
            div_b_reg     <= '0;
            last_reg      <= '0;
            step_reg      <= '0;
            lvl_reg[0]    <= '0;
            lvl_reg[1]    <= '0;
            lvl_reg[2]    <= '0;
            n_reg         <= '0;
            col_reg       <= '0;
            sc_reg        <= '0;
            ratio_reg     <= '0;
            remk_reg      <= '0;
            mix_reg       <= '0;
            chan_reg      <= '0;
            prod_reg      <= '0;
            written_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            wr_out_reg    <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            // Drop a taken result unless the output stage reloads it this cycle
            if (out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        written_reg <= 1'b0;
                        state_reg   <= S_OUT;
                        if (action == rle_pkg::ACT_TICK && tick_go)
                        begin
                            // Mark the update and find the step count first
                            last_reg  <= now_ms;
                            div_a_reg <= rle_pkg::DIV_W'(cfg.period);
                            div_b_reg <= rle_pkg::DVS_W'(rle_pkg::TICK_MS);
                            go_reg    <= 1'b1;
                            state_reg <= S_NDIV;
                        end
                        else if (action == rle_pkg::ACT_RESTART)
                        begin
                            last_reg <= now_ms;
                            step_reg <= '0;
                        end
                    end
                end

                S_NDIV:
                begin
                    if (div_stat.done)
                    begin
                        n_reg <= n_val;
                        case (cfg.mode)
                            rle_pkg::MODE_BREATH:
                            begin
                                div_a_reg <= rle_pkg::DIV_W'({step_reg, {rle_pkg::SINE_W{1'b0}}});
                                div_b_reg <= rle_pkg::DVS_W'(n_val);
                                go_reg    <= 1'b1;
                                step_reg  <= step_wrap;
                                state_reg <= S_SDIV;
                            end
                            rle_pkg::MODE_FLOW:
                            begin
                                col_reg   <= flow_col;
                                sc_reg    <= rle_pkg::alpha_eff(flow_col);
                                chan_reg  <= rle_pkg::CH_RED;
                                step_reg  <= (flow_st_inc >= cnt) ? 16'd0 : 16'(flow_st_inc);
                                state_reg <= S_MUL1;
                            end
                            rle_pkg::MODE_GRAD:
                            begin
                                // step * 255 as a shift and subtract
                                div_a_reg <= rle_pkg::DIV_W'({step_reg, 8'h00})
                                             - rle_pkg::DIV_W'(step_reg);
                                div_b_reg <= rle_pkg::DVS_W'(n_val);
                                go_reg    <= 1'b1;
                                step_reg  <= step_wrap;
                                state_reg <= S_SDIV;
                            end
                            default:
                            begin
                                // Blink: step mod n, step wraps only at 16 bits
                                div_a_reg <= rle_pkg::DIV_W'(step_reg);
                                div_b_reg <= rle_pkg::DVS_W'(n_val);
                                go_reg    <= 1'b1;
                                step_reg  <= step_inc;
                                state_reg <= S_SDIV;
                            end
                        endcase
                    end
                end

                S_SDIV:
                begin
                    if (div_stat.done)
                    begin
                        case (cfg.mode)
                            rle_pkg::MODE_BREATH:
                            begin
                                sc_reg    <= rle_pkg::SINE_TAB[div_quo[rle_pkg::SINE_W-1:0]];
                                col_reg   <= cfg.color_a;
                                chan_reg  <= rle_pkg::CH_RED;
                                state_reg <= S_MUL1;
                            end
                            rle_pkg::MODE_GRAD:
                            begin
                                ratio_reg <= ratio_val;
                                chan_reg  <= rle_pkg::CH_RED;
                                state_reg <= S_BL;
                            end
                            default:
                            begin
                                remk_reg  <= div_rem[rle_pkg::N_W-1:0];
                                div_a_reg <= rle_pkg::DIV_W'(n_reg >> 1)
                                             * rle_pkg::DIV_W'(cfg.duty);
                                div_b_reg <= rle_pkg::DUTY_DIV;
                                go_reg    <= 1'b1;
                                state_reg <= S_ODIV;
                            end
                        endcase
                    end
                end

                S_ODIV:
                begin
                    if (div_stat.done)
                    begin
                        if (rle_pkg::DIV_W'(remk_reg) < div_quo)
                        begin
                            col_reg   <= cfg.color_a;
                            sc_reg    <= rle_pkg::alpha_eff(cfg.color_a);
                            chan_reg  <= rle_pkg::CH_RED;
                            state_reg <= S_MUL1;
                        end
                        else
                        begin
                            // Off phase: drop all levels
                            lvl_reg[0]  <= '0;
                            lvl_reg[1]  <= '0;
                            lvl_reg[2]  <= '0;
                            written_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end
                    end
                end

                S_BL:
                begin
                    div_a_reg <= rle_pkg::DIV_W'(bmag) * rle_pkg::DIV_W'(ratio_reg);
                    div_b_reg <= rle_pkg::BLEND_DIV;
                    go_reg    <= 1'b1;
                    state_reg <= S_BDIV;
                end

                S_BDIV:
                begin
                    if (div_stat.done)
                    begin
                        mix_reg <= mix_next;
                        if (chan_reg == rle_pkg::CH_ALPHA)
                        begin
                            col_reg   <= mix_next;
                            sc_reg    <= rle_pkg::alpha_eff(mix_next);
                            chan_reg  <= rle_pkg::CH_RED;
                            state_reg <= S_MUL1;
                        end
                        else
                        begin
                            chan_reg  <= chan_reg + 2'd1;
                            state_reg <= S_BL;
                        end
                    end
                end

                S_MUL1:
                begin
                    prod_reg  <= 16'(rle_pkg::col_byte(col_reg, chan_reg)) * 16'(sc_reg);
                    state_reg <= S_MUL2;
                end

                S_MUL2:
                begin
                    div_a_reg <= rle_pkg::DIV_W'(prod_reg) * rle_pkg::DIV_W'(cfg.brightness);
                    div_b_reg <= rle_pkg::LEVEL_DIV;
                    go_reg    <= 1'b1;
                    state_reg <= S_LDIV;
                end

                S_LDIV:
                begin
                    if (div_stat.done)
                    begin
                        lvl_reg[chan_reg] <= div_quo[7:0];
                        if (chan_reg == rle_pkg::CH_BLUE)
                        begin
                            written_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end
                        else
                        begin
                            chan_reg  <= chan_reg + 2'd1;
                            state_reg <= S_MUL1;
                        end
                    end
                end

                S_OUT:
                begin
                    // Hold here until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        red_reg       <= {lvl_reg[0], lvl_reg[0]};
                        green_reg     <= {lvl_reg[1], lvl_reg[1]};
                        blue_reg      <= {lvl_reg[2], lvl_reg[2]};
                        wr_out_reg    <= written_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;
    assign pwm_written = wr_out_reg;

`ifndef SYNTHESIS
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_NDIV || state_reg == S_SDIV ||
                           state_reg == S_ODIV || state_reg == S_BDIV ||
                           state_reg == S_LDIV))
        else $error("divider finished while sequencer was not waiting");

    a_no_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |-> !div_stat.busy)
        else $error("divide launched while divider busy");

    a_level_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_level[15:8] == red_level[7:0]
                       && green_level[15:8] == green_level[7:0]
                       && blue_level[15:8] == blue_level[7:0]))
        else $error("compare level is not an 8-bit level times 257");

    a_out_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || out_ready))
        |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not handed to output register");
`endif

endmodule

`default_nettype wire

// ===== src/rle_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module rle_div (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire [rle_pkg::DIV_W-1:0]    dividend,
    input  wire [rle_pkg::DVS_W-1:0]    divisor,
    output rle_pkg::div_stat_t          stat,
    output logic [rle_pkg::DIV_W-1:0]   quo,
    output logic [rle_pkg::DVS_W-1:0]   rem
);

    logic [rle_pkg::DIV_W-1:0]  dq_reg;
    logic [rle_pkg::DVS_W-1:0]  rem_reg;
    logic [rle_pkg::DVS_W-1:0]  dvs_reg;
    logic [rle_pkg::DIV_CW-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [rle_pkg::DVS_W:0]    partial;
    logic                       ge;
    logic [rle_pkg::DVS_W:0]    diff;

    assign partial = {rem_reg, dq_reg[rle_pkg::DIV_W-1]};
    assign ge      = partial >= {1'b0, dvs_reg};
    assign diff    = partial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= rle_pkg::DIV_CW'(rle_pkg::DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rle_pkg::DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[rle_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[rle_pkg::DVS_W-1:0] : partial[rle_pkg::DVS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = dq_reg;
    assign rem       = rem_reg;

endmodule

`default_nettype wire

// ===== src/rle_cfg.sv =====
// APB register bank holding the effect configuration.
`default_nettype none

module rle_cfg (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [rle_pkg::CFG_AW-1:0]    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rle_pkg::cfg_t                cfg
);

    rle_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= rle_pkg::MODE_NONE;
            cfg_reg.period     <= 16'd1000;
            cfg_reg.color_a    <= '0;
            cfg_reg.color_b    <= '0;
            cfg_reg.brightness <= 8'hFF;
            cfg_reg.duty       <= 7'd50;
            cfg_reg.flow_count <= 4'd1;
        end
        else if (wr_en)
        begin
            case (idx)
                rle_pkg::REG_MODE:     cfg_reg.mode       <= pwdata[2:0];
                rle_pkg::REG_PERIOD:   cfg_reg.period     <= pwdata[15:0];
                rle_pkg::REG_COLOR_A:  cfg_reg.color_a    <= pwdata;
                rle_pkg::REG_COLOR_B:  cfg_reg.color_b    <= pwdata;
                rle_pkg::REG_BRIGHT:   cfg_reg.brightness <= pwdata[7:0];
                rle_pkg::REG_DUTY:     cfg_reg.duty       <= (pwdata[6:0] > rle_pkg::DUTY_MAX)
                                                             ? rle_pkg::DUTY_MAX : pwdata[6:0];
                rle_pkg::REG_FLOW_CNT: cfg_reg.flow_count <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rle_pkg::REG_MODE:     prdata = {29'd0, cfg_reg.mode};
            rle_pkg::REG_PERIOD:   prdata = {16'd0, cfg_reg.period};
            rle_pkg::REG_COLOR_A:  prdata = cfg_reg.color_a;
            rle_pkg::REG_COLOR_B:  prdata = cfg_reg.color_b;
            rle_pkg::REG_BRIGHT:   prdata = {24'd0, cfg_reg.brightness};
            rle_pkg::REG_DUTY:     prdata = {25'd0, cfg_reg.duty};
            rle_pkg::REG_FLOW_CNT: prdata = {28'd0, cfg_reg.flow_count};
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/rgb_led_effect_engine_tb.sv =====
// Testbench of the RGB LED effect engine: scoreboard class, drivers and stimulus.
`default_nettype none

module rgb_led_effect_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code that the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Register index past the end of the map
    localparam logic [2:0] REG_NONE   = 3'd7;
    localparam int         STALL_LIMIT = 5000;
    localparam int         DRAIN_WAIT  = 300;
    localparam int         PHASE_ITEMS = 45;

    // Scoreboard: holds its own copy of the engine state and predicts the
    // levels that each accepted request leaves on the outputs.
    class led_scoreboard;
        typedef struct {
            bit [15:0] red;
            bit [15:0] green;
            bit [15:0] blue;
            bit        written;
        } levels_t;

        bit [2:0]  mode;
        bit [15:0] period;
        bit [31:0] col_a;
        bit [31:0] col_b;
        bit [7:0]  bright;
        bit [6:0]  duty;
        bit [3:0]  flow_cnt;
        bit [31:0] last_ms;
        bit [15:0] step;
        bit [31:0] flow_mem [rle_pkg::FLOW_DEPTH];
        bit [15:0] lvl [3];
        bit [7:0]  wave [rle_pkg::SINE_ENTRIES];
        levels_t   due_levels [$];
        int        errors;
        int        writes_seen;

        function new();
            mode = rle_pkg::MODE_NONE;
            period = 16'd1000;
            col_a = '0;
            col_b = '0;
            bright = 8'd255;
            duty = 7'd50;
            flow_cnt = 4'd1;
            last_ms = '0;
            step = '0;
            foreach (flow_mem[i]) flow_mem[i] = '0;
            foreach (lvl[i]) lvl[i] = '0;
            errors = 0;
            writes_seen = 0;
            make_wave();
        endfunction

        function longint unsigned clip_sub(longint unsigned a, longint unsigned b);
            return (b > a) ? 0 : a - b;
        endfunction

        // (1 + sin) / 2 in Q0.8 from a truncated Q24 Taylor series
        function void make_wave();
            longint unsigned one, q, r, ang, sq, acc, v, num;
            one = 64'd1 << 24;
            for (int i = 0; i < rle_pkg::SINE_ENTRIES; i++)
            begin
                q = (4 * i) / rle_pkg::SINE_ENTRIES;
                r = 4 * i - q * rle_pkg::SINE_ENTRIES;
                ang = (r * 64'd26353589) / rle_pkg::SINE_ENTRIES;
                sq = (ang * ang) >> 24;
                if (q % 2 == 0)
                begin
                    acc = clip_sub(one, sq / 72);
                    acc = clip_sub(one, ((sq * acc) >> 24) / 42);
                    acc = clip_sub(one, ((sq * acc) >> 24) / 20);
                    acc = clip_sub(one, ((sq * acc) >> 24) / 6);
                    v = (ang * acc) >> 24;
                end
                else
                begin
                    acc = clip_sub(one, sq / 90);
                    acc = clip_sub(one, ((sq * acc) >> 24) / 56);
                    acc = clip_sub(one, ((sq * acc) >> 24) / 30);
                    acc = clip_sub(one, ((sq * acc) >> 24) / 12);
                    acc = clip_sub(one, ((sq * acc) >> 24) / 2);
                    v = acc;
                end
                if (v > one) v = one;
                num = (q < 2) ? one + v : one - v;
                wave[i] = 8'((num * 255 + one) / (2 * one));
            end
        endfunction

        function void set_reg(bit [2:0] idx, bit [31:0] val);
            case (idx)
                rle_pkg::REG_MODE:     mode = val[2:0];
                rle_pkg::REG_PERIOD:   period = val[15:0];
                rle_pkg::REG_COLOR_A:  col_a = val;
                rle_pkg::REG_COLOR_B:  col_b = val;
                rle_pkg::REG_BRIGHT:   bright = val[7:0];
                rle_pkg::REG_DUTY:     duty = (val[6:0] > 7'd100) ? 7'd100 : val[6:0];
                rle_pkg::REG_FLOW_CNT: flow_cnt = val[3:0];
                default: ;
            endcase
        endfunction

        function void put8(int unsigned r, int unsigned g, int unsigned b);
            lvl[0] = 16'((r & 255) * 257);
            lvl[1] = 16'((g & 255) * 257);
            lvl[2] = 16'((b & 255) * 257);
        endfunction

        function void show(bit [31:0] c);
            int unsigned al;
            al = c[31:24];
            if (al == 0 && c[23:0] != 0) al = 255;
            put8(c[23:16] * al * bright / 65025, c[15:8] * al * bright / 65025,
                 c[7:0] * al * bright / 65025);
        endfunction

        function bit [7:0] blend(bit [7:0] c1, bit [7:0] c2, int unsigned ratio);
            int d;
            d = int'(c2) - int'(c1);
            return 8'(int'(c1) + (d * int'(ratio)) / 255);
        endfunction

        // Advance the selected effect; return 1 when the levels were written
        function bit tick(bit [31:0] t);
            bit [31:0]   el;
            int unsigned n, cnt, idx, s, ratio, on;
            el = t - last_ms;
            n = period / rle_pkg::TICK_MS;
            if (n == 0) n = 1;
            case (mode)
                rle_pkg::MODE_BREATH:
                begin
                    if (el < rle_pkg::TICK_MS) return 0;
                    last_ms = t;
                    idx = (step * rle_pkg::SINE_ENTRIES / n) % rle_pkg::SINE_ENTRIES;
                    s = wave[idx];
                    put8(col_a[23:16] * s * bright / 65025, col_a[15:8] * s * bright / 65025,
                         col_a[7:0] * s * bright / 65025);
                    step++;
                    if (step >= n) step = 0;
                    return 1;
                end
                rle_pkg::MODE_FLOW:
                begin
                    cnt = (flow_cnt == 0) ? 1 : flow_cnt;
                    if (cnt > rle_pkg::FLOW_DEPTH) cnt = rle_pkg::FLOW_DEPTH;
                    if (el < period) return 0;
                    last_ms = t;
                    if (step >= cnt) step = 0;
                    show(flow_mem[step]);
                    step++;
                    if (step >= cnt) step = 0;
                    return 1;
                end
                rle_pkg::MODE_GRAD:
                begin
                    if (el < rle_pkg::TICK_MS) return 0;
                    last_ms = t;
                    ratio = step * 255 / n;
                    if (ratio > 255) ratio = 255;
                    show({blend(col_a[31:24], col_b[31:24], ratio),
                          blend(col_a[23:16], col_b[23:16], ratio),
                          blend(col_a[15:8], col_b[15:8], ratio),
                          blend(col_a[7:0], col_b[7:0], ratio)});
                    step++;
                    if (step >= n) step = 0;
                    return 1;
                end
                rle_pkg::MODE_BLINK:
                begin
                    if (el < rle_pkg::TICK_MS) return 0;
                    last_ms = t;
                    on = (n / 2) * duty / 50;
                    if ((step % n) < on) show(col_a);
                    else put8(0, 0, 0);
                    step++;
                    return 1;
                end
                default: return 0;
            endcase
        endfunction

        function void note_request(bit [1:0] act, bit [31:0] t, bit [2:0] idx,
                                   bit [31:0] col);
            levels_t e;
            e.written = 0;
            case (act)
                rle_pkg::ACT_TICK:    e.written = tick(t);
                rle_pkg::ACT_RESTART:
                begin
                    last_ms = t;
                    step = 0;
                end
                rle_pkg::ACT_LOAD:    flow_mem[idx] = col;
                default: ;
            endcase
            e.red = lvl[0];
            e.green = lvl[1];
            e.blue = lvl[2];
            if (e.written) writes_seen++;
            due_levels.push_back(e);
        endfunction

        function void check_result(bit [15:0] r, bit [15:0] g, bit [15:0] b, bit w);
            levels_t e;
            if (due_levels.size() == 0)
            begin
                $display("%0t: unexpected result r=%h g=%h b=%h w=%b", $realtime, r, g, b, w);
                errors++;
                return;
            end
            e = due_levels.pop_front();
            if (r !== e.red)
            begin
                $display("%0t: red_level expected %h actual %h", $realtime, e.red, r);
                errors++;
            end
            if (g !== e.green)
            begin
                $display("%0t: green_level expected %h actual %h", $realtime, e.green, g);
                errors++;
            end
            if (b !== e.blue)
            begin
                $display("%0t: blue_level expected %h actual %h", $realtime, e.blue, b);
                errors++;
            end
            if (w !== e.written)
            begin
                $display("%0t: pwm_written expected %b actual %b", $realtime, e.written, w);
                errors++;
            end
        endfunction

        function int pending();
            return due_levels.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [2:0]  flow_index;
    logic [31:0] flow_color;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
    logic        pwm_written;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [rle_pkg::CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgb_led_effect_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .now_ms(now_ms), .flow_index(flow_index), .flow_color(flow_color),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_level(red_level), .green_level(green_level), .blue_level(blue_level),
        .pwm_written(pwm_written),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    led_scoreboard sb = new();

    int          send_idle_pct;   // chance in percent that the sender skips a cycle
    int          recv_idle_pct;   // chance in percent that the receiver stalls a cycle
    int          hold_left;       // long receiver hold-off, counted down per cycle
    int          quiet_cycles;    // cycles since the last handshake
    int          requests_done;
    int          results_done;
    logic [31:0] clock_ms;        // running millisecond time stamp

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall at random, or hold off completely while hold_left runs
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: note accepted requests, check accepted results, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_request(action, now_ms, flow_index, flow_color);
                requests_done++;
            end
            if (out_valid && out_ready)
            begin
                sb.check_result(red_level, green_level, blue_level, pwm_written);
                results_done++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("rgb_led_effect_engine: mismatch");
                $finish;
            end
        end
    end

    // Write one register: setup cycle, then access cycle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rle_pkg::CFG_AW'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        sb.set_reg(idx, val);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one request, idling first at random; hold it until accepted
    task automatic send_request(logic [1:0] act, logic [31:0] t, logic [2:0] idx,
                                logic [31:0] col);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        now_ms <= t;
        flow_index <= idx;
        flow_color <= col;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_line();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait for every expected result, then let a slow tick finish
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Mostly ticks that are due, some too early, some restarts, loads and junk
    task automatic random_request(int mode_sel, int per);
        int          roll;
        logic [1:0]  act;
        roll = $urandom_range(0, 99);
        if (roll < 70) act = rle_pkg::ACT_TICK;
        else if (roll < 80) act = rle_pkg::ACT_RESTART;
        else if (roll < 95) act = rle_pkg::ACT_LOAD;
        else act = ACT_UNUSED;
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom();
        else if (act == rle_pkg::ACT_TICK)
        begin
            if ($urandom_range(0, 4) == 0)
                clock_ms += $urandom_range(0, 9);
            else if (mode_sel == rle_pkg::MODE_FLOW)
                clock_ms += per + $urandom_range(0, 20);
            else
                clock_ms += $urandom_range(10, 40);
        end
        send_request(act, clock_ms, 3'($urandom_range(0, 7)), $urandom());
    endtask

    // Per-phase settings; the list walks every mode and the register extremes
    int          ph_mode [12]   = '{1, 2, 3, 4, 1, 2, 3, 4, 2, 1, 0, 5};
    int          ph_period [12] = '{1000, 30, 100, 200, 0, 65535, 5, 65535, 0, 50, 20, 100};
    int          ph_bright [12] = '{255, 255, 128, 255, 0, 200, 255, 1, 255, 77, 255, 255};
    int          ph_duty [12]   = '{50, 50, 50, 0, 50, 50, 50, 100, 50, 50, 127, 50};
    int          ph_fcnt [12]   = '{1, 8, 1, 1, 1, 3, 1, 1, 0, 15, 1, 1};

    logic [31:0] seed_colors [8] = '{32'hFFFFFFFF, 32'h00000000, 32'h00FF8040,
                                     32'h80FFFFFF, 32'h01010101, 32'hFF000000,
                                     32'h7F123456, 32'hFF00FF00};

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = rle_pkg::ACT_TICK;
        now_ms = '0;
        flow_index = '0;
        flow_color = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        requests_done = 0;
        results_done = 0;
        clock_ms = 32'd100;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: fill the whole flow table first so no flow tick ever reads an
        // unwritten entry; then ticks with the effect off, a restart, an ignored
        // action and the time stamp extremes.
        for (int i = 0; i < rle_pkg::FLOW_DEPTH; i++)
            send_request(rle_pkg::ACT_LOAD, clock_ms, 3'(i), seed_colors[i]);
        send_request(rle_pkg::ACT_TICK, 32'd0, 3'd7, 32'hFFFFFFFF);
        send_request(rle_pkg::ACT_TICK, 32'hFFFFFFFF, 3'd0, 32'd0);
        send_request(rle_pkg::ACT_RESTART, 32'hFFFFFFF0, 3'd5, 32'hA5A5A5A5);
        send_request(ACT_UNUSED, 32'h5A5A5A5A, 3'd2, 32'h12345678);
        send_request(rle_pkg::ACT_TICK, 32'h00000004, 3'd1, 32'h0);
        idle_line();
        drain();

        for (int p = 0; p < 12; p++)
        begin
            // Idle pattern: receiver lazy first, then sender lazy, then full speed
            if (p < 4)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 85;
            end
            else if (p < 8)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            reg_write(rle_pkg::REG_MODE, 32'(ph_mode[p]) | ($urandom() & 32'hFFFFFFF8));
            reg_write(rle_pkg::REG_PERIOD, 32'(ph_period[p]));
            reg_write(rle_pkg::REG_COLOR_A, (p == 0) ? 32'hFFFFFFFF : $urandom());
            reg_write(rle_pkg::REG_COLOR_B, (p == 2) ? 32'h00000000 : $urandom());
            reg_write(rle_pkg::REG_BRIGHT, 32'(ph_bright[p]));
            reg_write(rle_pkg::REG_DUTY, 32'(ph_duty[p]));
            reg_write(rle_pkg::REG_FLOW_CNT, 32'(ph_fcnt[p]));
            if (p == 10)
                reg_write(REG_NONE, $urandom());

            // Restart so the effect begins from a known time stamp
            send_request(rle_pkg::ACT_RESTART, clock_ms, 3'd0, 32'd0);

            // Hold the receiver off while requests keep coming: the block fills
            // and must stall its input until results drain.
            if (p == 8)
                hold_left = 600;

            for (int k = 0; k < PHASE_ITEMS; k++)
                random_request(ph_mode[p], ph_period[p]);
            idle_line();
            drain();
        end

        $display("covered %0d requests and %0d results, %0d level updates,",
                 requests_done, results_done, sb.writes_seen);
        $display("all five modes plus an unused one, period and count extremes, stalls");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("rgb_led_effect_engine: match");
        else
            $display("rgb_led_effect_engine: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/rle_pkg.sv
src/rle_div.sv
src/rle_cfg.sv
src/rgb_led_effect_engine.sv
bench/rgb_led_effect_engine_tb.sv
